>>> rtl/rfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the first-fit rectangle placer.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int DEF_MAX_CANVAS_WIDTH  = 64;
  localparam int DEF_MAX_CANVAS_HEIGHT = 64;

  // width of every size and register field
  localparam int DIM_W = 7;
  // width of the reported position fields
  localparam int POS_W = 6;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic clr;
  } map_ctl_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } result_t;

endpackage

>>> rtl/rfp_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_map
// Occupancy map: one row of bits per canvas row, registered read port,
// one write port, per-row valid bits so a clear empties the map at once.
// ----------------------------------------------------------------------------
module rfp_map #(
  parameter int MAX_W = rfp_pkg::DEF_MAX_CANVAS_WIDTH,
  parameter int MAX_H = rfp_pkg::DEF_MAX_CANVAS_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rfp_pkg::map_ctl_t        ctl,
  input  logic [$clog2(MAX_H)-1:0] rd_addr,
  input  logic [$clog2(MAX_H)-1:0] wr_addr,
  input  logic [MAX_W-1:0]         wr_data,
  output logic [MAX_W-1:0]         rd_row
);

  logic [MAX_W-1:0] mem [MAX_H];
  logic [MAX_H-1:0] row_valid;
  logic [MAX_W-1:0] rd_raw;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_vld <= row_valid[rd_addr];
    if (rst) begin
      row_valid <= '0;
    end else if (ctl.clr) begin
      row_valid <= '0;
    end else if (ctl.wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // a row never written since the last clear reads as empty
  assign rd_row = rd_vld ? rd_raw : '0;

endmodule

>>> rtl/rfp_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_search
// Sequencer of the first-fit search: walks columns, streams rows through one
// masked-compare unit while counting free runs, then marks the found area.
// ----------------------------------------------------------------------------
module rfp_search #(
  parameter int MAX_W = rfp_pkg::DEF_MAX_CANVAS_WIDTH,
  parameter int MAX_H = rfp_pkg::DEF_MAX_CANVAS_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_op,
  input  logic [rfp_pkg::DIM_W-1:0]  req_w,
  input  logic [rfp_pkg::DIM_W-1:0]  req_h,
  input  logic [rfp_pkg::DIM_W-1:0]  cw,
  input  logic [rfp_pkg::DIM_W-1:0]  ch,
  input  logic [MAX_W-1:0]           map_row,
  input  logic                       res_take,
  output logic                       busy,
  output rfp_pkg::map_ctl_t          map_ctl,
  output logic [$clog2(MAX_H)-1:0]   map_rd_addr,
  output logic [$clog2(MAX_H)-1:0]   map_wr_addr,
  output logic [MAX_W-1:0]           map_wr_data,
  output logic                       res_valid,
  output rfp_pkg::result_t           res
);

  localparam int DW = rfp_pkg::DIM_W;
  localparam int YW = $clog2(MAX_H);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_t;

  state_t           state;
  logic [DW-1:0]    x;
  logic [DW-1:0]    y_rd;
  logic             iss;
  logic             ev;
  logic [DW-1:0]    ev_y;
  logic [DW-1:0]    run;
  logic [DW-1:0]    mrow;
  logic [DW-1:0]    pos_y_r;
  logic [DW-1:0]    w_r;
  logic [DW-1:0]    h_r;
  logic [DW-1:0]    cw_r;
  logic [DW-1:0]    ch_r;
  logic [MAX_W-1:0] mask;
  logic             found_r;

  logic [MAX_W:0]   ones_ext;
  logic             hit;
  logic [DW-1:0]    run_inc;
  logic [DW-1:0]    ch_last;
  logic [DW-1:0]    mark_last;
  logic [DW:0]      x_end;
  logic             last_x;
  logic             bad_size;

  assign ones_ext  = ((MAX_W + 1)'(1) << req_w) - (MAX_W + 1)'(1);
  // shared unit: one masked row compare per cycle
  assign hit       = |(map_row & mask);
  assign run_inc   = run + DW'(1);
  assign ch_last   = ch_r - DW'(1);
  assign mark_last = pos_y_r + h_r - DW'(1);
  assign x_end     = {1'b0, x} + {1'b0, w_r};
  assign last_x    = (x_end == {1'b0, cw_r});
  assign bad_size  = (req_w == '0) || (req_h == '0) || (req_w > cw) || (req_h > ch);

  assign busy        = (state != ST_IDLE);
  assign map_rd_addr = (state == ST_MARK_RD) ? YW'(mrow) : YW'(y_rd);
  assign map_wr_addr = YW'(mrow);
  assign map_wr_data = map_row | mask;
  assign map_ctl.wr_en = (state == ST_MARK_WR);
  assign map_ctl.clr   = (state == ST_IDLE) && req_valid && (req_op == rfp_pkg::OP_CLEAR);

  assign res_valid   = (state == ST_DONE);
  assign res.found   = found_r;
  assign res.pos_x   = found_r ? rfp_pkg::POS_W'(x) : '0;
  assign res.pos_y   = found_r ? rfp_pkg::POS_W'(pos_y_r) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iss   <= 1'b0;
      ev    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            found_r <= 1'b0;
            if (req_op == rfp_pkg::OP_CLEAR || bad_size) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
              w_r   <= req_w;
              h_r   <= req_h;
              cw_r  <= cw;
              ch_r  <= ch;
              x     <= '0;
              y_rd  <= '0;
              iss   <= 1'b1;
              ev    <= 1'b0;
              run   <= '0;
              mask  <= ones_ext[MAX_W-1:0];
            end
          end
        end
        ST_SCAN: begin
          if (iss) begin
            if (y_rd == ch_last) begin
              iss <= 1'b0;
            end else begin
              y_rd <= y_rd + DW'(1);
            end
          end
          ev   <= iss;
          ev_y <= y_rd;
          if (ev) begin
            if (!hit && run_inc == h_r) begin
              // free run of h rows ends here
              state   <= ST_MARK_RD;
              mrow    <= ev_y - h_r + DW'(1);
              pos_y_r <= ev_y - h_r + DW'(1);
              iss     <= 1'b0;
              ev      <= 1'b0;
            end else begin
              run <= hit ? '0 : run_inc;
              if (ev_y == ch_last) begin
                if (last_x) begin
                  state <= ST_DONE;
                end else begin
                  x    <= x + DW'(1);
                  mask <= mask << 1;
                  y_rd <= '0;
                  iss  <= 1'b1;
                  ev   <= 1'b0;
                  run  <= '0;
                end
              end
            end
          end
        end
        ST_MARK_RD: begin
          state <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          if (mrow == mark_last) begin
            state   <= ST_DONE;
            found_r <= 1'b1;
          end else begin
            mrow  <= mrow + DW'(1);
            state <= ST_MARK_RD;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // column walk never runs past the last fitting corner
  a_x_in_canvas: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (x_end <= {1'b0, cw_r}))
    else $error("column scan beyond canvas");

  // a run reaching the height always ends the column scan
  a_run_below_h: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (run < h_r))
    else $error("free run count reached rectangle height");

  // every row write is preceded by its read
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK_WR) |-> ($past(state) == ST_MARK_RD))
    else $error("row write without preceding read");

  // a reported area does not reach past the canvas bottom
  a_found_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && found_r) |->
      (({1'b0, pos_y_r} + {1'b0, h_r}) <= {1'b0, ch_r}))
    else $error("placed area below canvas bottom");

endmodule

>>> rtl/first_fit_rect_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_rect_placer
// First-fit placement of rectangles on a one-bit occupancy map.
// ----------------------------------------------------------------------------
// a clear request or a size that cannot fit goes to its result without a scan
// a place request scans the rows of each candidate column in turn, then marks
// the found rows, each by a read and a write
// one row is read and compared per cycle through the single map read port
// one request at a time; a new request is taken once the result is handed on
// reset empties the map at once through per-row valid bits, no clearing pass
module first_fit_rect_placer #(
  parameter int MAX_CANVAS_WIDTH  = rfp_pkg::DEF_MAX_CANVAS_WIDTH,
  parameter int MAX_CANVAS_HEIGHT = rfp_pkg::DEF_MAX_CANVAS_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rfp_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [rfp_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [rfp_pkg::DIM_W-1:0]         rect_width,
  input  logic [rfp_pkg::DIM_W-1:0]         rect_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic [rfp_pkg::POS_W-1:0]         pos_x,
  output logic [rfp_pkg::POS_W-1:0]         pos_y
);

  localparam int DW = rfp_pkg::DIM_W;
  localparam int YW = $clog2(MAX_CANVAS_HEIGHT);
  // a 7-bit height register can only exceed maxima below 128
  localparam bit SAT_H = (MAX_CANVAS_HEIGHT < 128);

  logic [DW-1:0]                width_reg;
  logic [DW-1:0]                height_reg;
  logic [DW-1:0]                cw_eff;
  logic [DW-1:0]                ch_eff;
  logic                         busy;
  logic                         req_valid;
  logic                         res_valid;
  logic                         res_take;
  rfp_pkg::result_t             res;
  rfp_pkg::map_ctl_t            map_ctl;
  logic [YW-1:0]                map_rd_addr;
  logic [YW-1:0]                map_wr_addr;
  logic [MAX_CANVAS_WIDTH-1:0]  map_wr_data;
  logic [MAX_CANVAS_WIDTH-1:0]  map_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DW'(64);
      height_reg <= DW'(64);
    end else if (cfg_write) begin
      unique case (cfg_index)
        rfp_pkg::REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
        rfp_pkg::REG_CANVAS_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cw_eff = (width_reg > DW'(MAX_CANVAS_WIDTH)) ? DW'(MAX_CANVAS_WIDTH) : width_reg;
  assign ch_eff = (SAT_H && height_reg > DW'(MAX_CANVAS_HEIGHT)) ?
                  DW'(MAX_CANVAS_HEIGHT) : height_reg;

  assign in_stall  = busy;
  assign req_valid = in_valid && !busy;
  assign res_take  = res_valid && (!out_valid || !out_stall);

  // output register parts the result from the search
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      found <= res.found;
      pos_x <= res.pos_x;
      pos_y <= res.pos_y;
    end
  end

  rfp_search #(
    .MAX_W (MAX_CANVAS_WIDTH),
    .MAX_H (MAX_CANVAS_HEIGHT)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_op      (operation),
    .req_w       (rect_width),
    .req_h       (rect_height),
    .cw          (cw_eff),
    .ch          (ch_eff),
    .map_row     (map_row),
    .res_take    (res_take),
    .busy        (busy),
    .map_ctl     (map_ctl),
    .map_rd_addr (map_rd_addr),
    .map_wr_addr (map_wr_addr),
    .map_wr_data (map_wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  rfp_map #(
    .MAX_W (MAX_CANVAS_WIDTH),
    .MAX_H (MAX_CANVAS_HEIGHT)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (map_ctl),
    .rd_addr (map_rd_addr),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_row  (map_row)
  );

endmodule
